>>> src/i2cms_pkg.sv
package i2cms_pkg;

    localparam int unsigned KindWidth   = 2;
    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned CountWidth  = 16;
    localparam int unsigned ActionWidth = 3;
    localparam int unsigned OutcomeWidth = 2;

    localparam int unsigned MaxResults  = 3;
    localparam int unsigned QueueDepth  = 4;

    typedef enum logic [KindWidth-1:0] {
        KIND_BEGIN  = 2'd0,
        KIND_WBYTE  = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [ActionWidth-1:0] {
        ACT_START   = 3'd0,
        ACT_TX      = 3'd1,
        ACT_RX_ACK  = 3'd2,
        ACT_RX_NACK = 3'd3,
        ACT_STOP    = 3'd4,
        ACT_NEED    = 3'd5,
        ACT_READ    = 3'd6,
        ACT_DONE    = 3'd7
    } action_t;

    typedef enum logic [OutcomeWidth-1:0] {
        OUT_OK     = 2'd0,
        OUT_NAK    = 2'd1,
        OUT_UNEXP  = 2'd2,
        OUT_RSVD   = 2'd3
    } outcome_t;

    localparam logic [ByteWidth-1:0] STATUS_MASK     = 8'hf8;
    localparam logic [ByteWidth-1:0] ST_START        = 8'h08;
    localparam logic [ByteWidth-1:0] ST_REP_START    = 8'h10;
    localparam logic [ByteWidth-1:0] ST_SLA_W_ACK    = 8'h18;
    localparam logic [ByteWidth-1:0] ST_SLA_W_NAK    = 8'h20;
    localparam logic [ByteWidth-1:0] ST_DATA_W_ACK   = 8'h28;
    localparam logic [ByteWidth-1:0] ST_DATA_W_NAK   = 8'h30;
    localparam logic [ByteWidth-1:0] ST_SLA_R_ACK    = 8'h40;
    localparam logic [ByteWidth-1:0] ST_SLA_R_NAK    = 8'h48;
    localparam logic [ByteWidth-1:0] ST_DATA_R_ACK   = 8'h50;
    localparam logic [ByteWidth-1:0] ST_DATA_R_NAK   = 8'h58;
    localparam logic [ByteWidth-1:0] WRITE_DIR_MASK  = 8'hfe;
    localparam logic [ByteWidth-1:0] READ_DIR_BIT    = 8'h01;

    typedef struct packed {
        logic [ActionWidth-1:0]  action;
        logic [ByteWidth-1:0]    tx_byte;
        logic [ByteWidth-1:0]    read_byte;
        logic [OutcomeWidth-1:0] outcome;
        logic [ByteWidth-1:0]    final_code;
        logic                    last;
    } result_t;

    function automatic result_t make_result(
        input action_t                act,
        input logic [ByteWidth-1:0]   tx,
        input logic [ByteWidth-1:0]   rd,
        input outcome_t               oc,
        input logic [ByteWidth-1:0]   code
    );
        result_t r;
        r.action     = act;
        r.tx_byte    = tx;
        r.read_byte  = rd;
        r.outcome    = oc;
        r.final_code = code;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

>>> src/i2cms_in_if.sv
interface i2cms_in_if
    import i2cms_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [KindWidth-1:0]   kind;
    logic [ByteWidth-1:0]   device_address;
    logic [CountWidth-1:0]  address_count;
    logic [CountWidth-1:0]  write_count;
    logic [CountWidth-1:0]  read_count;
    logic [ByteWidth-1:0]   data_byte;
    logic [ByteWidth-1:0]   bus_status;

    modport source (
        output valid, kind, device_address, address_count, write_count,
               read_count, data_byte, bus_status,
        input  ready
    );

    modport sink (
        input  valid, kind, device_address, address_count, write_count,
               read_count, data_byte, bus_status,
        output ready
    );
endinterface

>>> src/i2cms_out_if.sv
interface i2cms_out_if
    import i2cms_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [ActionWidth-1:0]  action;
    logic [ByteWidth-1:0]    tx_byte;
    logic [ByteWidth-1:0]    read_byte;
    logic [OutcomeWidth-1:0] outcome;
    logic [ByteWidth-1:0]    final_code;
    logic                    last;

    modport source (
        output valid, action, tx_byte, read_byte, outcome, final_code, last,
        input  ready
    );

    modport sink (
        input  valid, action, tx_byte, read_byte, outcome, final_code, last,
        output ready
    );
endinterface

>>> src/i2c_master_transaction_sequencer.sv
// i2c master transaction sequencer
// item channel: begin beats (device address and address/write/read counts),
// write byte beats, and bus engine status beats with the received byte.
// result channel: up to three beats per item (start, transmit, ack/nack
// receive, stop, need write byte, read byte, done); last marks the final
// beat of an item. items that do nothing here give no result beat.
// an item is taken into an input register; the step logic then updates
// the transaction state from it and pushes its beats into a four-entry
// result queue. one item per cycle is sustained while each item gives one
// beat and result ready stays high; the rate is set by the result port,
// which drains one beat a cycle while result ready is high.
// the input register moves on only when the queue has room for three
// beats, so a stalled receiver backs up into item ready without loss.
// reset clears the phase to idle, all counts and flags, the input register
// valid flag and the queue pointers and count.
module i2c_master_transaction_sequencer
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2cms_in_if.sink    item,
    i2cms_out_if.source result
);

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_W   = 4'd1,
        PH_SLA_W     = 4'd2,
        PH_NEED_BYTE = 4'd3,
        PH_DATA_TX   = 4'd4,
        PH_START_R   = 4'd5,
        PH_SLA_R     = 4'd6,
        PH_RX_ACK    = 4'd7,
        PH_RX_NACK   = 4'd8
    } phase_t;

    localparam int unsigned PtrWidth = $clog2(QueueDepth);
    localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

    // input register
    logic                  stage_valid_reg;
    logic [KindWidth-1:0]  kind_reg;
    logic [ByteWidth-1:0]  dev_reg;
    logic [CountWidth-1:0] acnt_reg;
    logic [CountWidth-1:0] wcnt_reg;
    logic [CountWidth-1:0] rcnt_reg;
    logic [ByteWidth-1:0]  data_reg;
    logic [ByteWidth-1:0]  status_reg;

    // transaction state
    phase_t                phase_reg, phase_next;
    logic [CountWidth-1:0] addr_left_reg, addr_left_next;
    logic [CountWidth-1:0] write_left_reg, write_left_next;
    logic [CountWidth-1:0] read_left_reg, read_left_next;
    logic [ByteWidth-1:0]  target_reg, target_next;
    logic                  wrote_reg, wrote_next;
    logic                  stop_pend_reg, stop_pend_next;

    // result queue
    result_t               queue_reg [QueueDepth];
    logic [PtrWidth-1:0]   wr_ptr_reg;
    logic [PtrWidth-1:0]   rd_ptr_reg;
    logic [CntWidth-1:0]   count_reg;

    result_t               res [MaxResults];
    logic [1:0]            n_res;
    logic                  pop;
    logic                  stage_go;
    logic                  take;
    logic [CntWidth-1:0]   count_after_pop;

    assign pop             = result.valid && result.ready;
    assign count_after_pop = count_reg - {{(CntWidth-1){1'b0}}, pop};
    assign stage_go        = stage_valid_reg
                             && (count_after_pop <= CntWidth'(QueueDepth - MaxResults));
    assign item.ready      = !stage_valid_reg || stage_go;
    assign take            = item.valid && item.ready;

    always_comb
    begin
        logic [ByteWidth-1:0]  s;
        logic [CountWidth-1:0] rl;
        logic [1:0]            n;
        logic                  more_write;

        phase_next      = phase_reg;
        addr_left_next  = addr_left_reg;
        write_left_next = write_left_reg;
        read_left_next  = read_left_reg;
        target_next     = target_reg;
        wrote_next      = wrote_reg;
        stop_pend_next  = stop_pend_reg;
        for (int i = 0; i < MaxResults; i++)
        begin
            res[i] = '0;
        end
        n          = 2'd0;
        s          = status_reg & STATUS_MASK;
        rl         = read_left_reg - {{(CountWidth-1){1'b0}}, (read_left_reg != '0)};
        more_write = (addr_left_reg != '0) || (write_left_reg != '0);

        if (stage_go)
        begin
            case (kind_reg)
                KIND_BEGIN:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        target_next     = dev_reg;
                        addr_left_next  = acnt_reg;
                        write_left_next = wcnt_reg;
                        read_left_next  = rcnt_reg;
                        if ((acnt_reg != '0) || (wcnt_reg != '0))
                        begin
                            wrote_next     = 1'b1;
                            stop_pend_next = 1'b1;
                            phase_next     = PH_START_W;
                            res[n] = make_result(ACT_START, '0, '0, OUT_OK, '0);
                            n = n + 2'd1;
                        end
                        else if (rcnt_reg != '0)
                        begin
                            wrote_next     = 1'b0;
                            stop_pend_next = 1'b1;
                            phase_next     = PH_START_R;
                            res[n] = make_result(ACT_START, '0, '0, OUT_OK, '0);
                            n = n + 2'd1;
                        end
                        else
                        begin
                            wrote_next     = 1'b0;
                            stop_pend_next = 1'b0;
                            phase_next     = PH_IDLE;
                            res[n] = make_result(ACT_DONE, '0, '0, OUT_OK, '0);
                            n = n + 2'd1;
                        end
                    end
                end
                KIND_WBYTE:
                begin
                    if (phase_reg == PH_NEED_BYTE)
                    begin
                        if (addr_left_reg != '0)
                        begin
                            addr_left_next = addr_left_reg - CountWidth'(1);
                        end
                        else if (write_left_reg != '0)
                        begin
                            write_left_next = write_left_reg - CountWidth'(1);
                        end
                        phase_next = PH_DATA_TX;
                        res[n] = make_result(ACT_TX, data_reg, '0, OUT_OK, '0);
                        n = n + 2'd1;
                    end
                end
                KIND_STATUS:
                begin
                    case (phase_reg)
                        PH_START_W:
                        begin
                            if (s != ST_START)
                            begin
                                phase_next = PH_IDLE;
                                res[n] = make_result(ACT_DONE, '0, '0, OUT_UNEXP, s);
                                n = n + 2'd1;
                            end
                            else
                            begin
                                phase_next = PH_SLA_W;
                                res[n] = make_result(ACT_TX, target_reg & WRITE_DIR_MASK,
                                                     '0, OUT_OK, '0);
                                n = n + 2'd1;
                            end
                        end
                        PH_SLA_W, PH_DATA_TX:
                        begin
                            if (((phase_reg == PH_SLA_W) && (s == ST_SLA_W_ACK))
                                || ((phase_reg == PH_DATA_TX) && (s == ST_DATA_W_ACK)))
                            begin
                                if (more_write)
                                begin
                                    phase_next = PH_NEED_BYTE;
                                    res[n] = make_result(ACT_NEED, '0, '0, OUT_OK, '0);
                                    n = n + 2'd1;
                                end
                                else if (read_left_reg != '0)
                                begin
                                    stop_pend_next = 1'b1;
                                    phase_next     = PH_START_R;
                                    res[n] = make_result(ACT_START, '0, '0, OUT_OK, '0);
                                    n = n + 2'd1;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                    res[n] = make_result(ACT_STOP, '0, '0, OUT_OK, '0);
                                    n = n + 2'd1;
                                    res[n] = make_result(ACT_DONE, '0, '0, OUT_OK, '0);
                                    n = n + 2'd1;
                                end
                            end
                            else if (((phase_reg == PH_SLA_W) && (s == ST_SLA_W_NAK))
                                     || ((phase_reg == PH_DATA_TX) && (s == ST_DATA_W_NAK)))
                            begin
                                phase_next = PH_IDLE;
                                if (stop_pend_reg)
                                begin
                                    res[n] = make_result(ACT_STOP, '0, '0, OUT_OK, '0);
                                    n = n + 2'd1;
                                end
                                res[n] = make_result(ACT_DONE, '0, '0, OUT_NAK, s);
                                n = n + 2'd1;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                res[n] = make_result(ACT_DONE, '0, '0, OUT_UNEXP, s);
                                n = n + 2'd1;
                            end
                        end
                        PH_START_R:
                        begin
                            if (s != (wrote_reg ? ST_REP_START : ST_START))
                            begin
                                phase_next = PH_IDLE;
                                res[n] = make_result(ACT_DONE, '0, '0, OUT_UNEXP, s);
                                n = n + 2'd1;
                            end
                            else
                            begin
                                phase_next = PH_SLA_R;
                                res[n] = make_result(ACT_TX, target_reg | READ_DIR_BIT,
                                                     '0, OUT_OK, '0);
                                n = n + 2'd1;
                            end
                        end
                        PH_SLA_R:
                        begin
                            if (s == ST_SLA_R_ACK)
                            begin
                                if (read_left_reg > CountWidth'(1))
                                begin
                                    phase_next = PH_RX_ACK;
                                    res[n] = make_result(ACT_RX_ACK, '0, '0, OUT_OK, '0);
                                end
                                else
                                begin
                                    phase_next = PH_RX_NACK;
                                    res[n] = make_result(ACT_RX_NACK, '0, '0, OUT_OK, '0);
                                end
                                n = n + 2'd1;
                            end
                            else if (s == ST_SLA_R_NAK)
                            begin
                                phase_next = PH_IDLE;
                                if (stop_pend_reg)
                                begin
                                    res[n] = make_result(ACT_STOP, '0, '0, OUT_OK, '0);
                                    n = n + 2'd1;
                                end
                                res[n] = make_result(ACT_DONE, '0, '0, OUT_NAK, s);
                                n = n + 2'd1;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                                res[n] = make_result(ACT_DONE, '0, '0, OUT_UNEXP, s);
                                n = n + 2'd1;
                            end
                        end
                        PH_RX_ACK:
                        begin
                            if (s != ST_DATA_R_ACK)
                            begin
                                phase_next = PH_IDLE;
                                res[n] = make_result(ACT_DONE, '0, '0, OUT_UNEXP, s);
                                n = n + 2'd1;
                            end
                            else
                            begin
                                res[n] = make_result(ACT_READ, '0, data_reg, OUT_OK, '0);
                                n = n + 2'd1;
                                read_left_next = rl;
                                if (rl > CountWidth'(1))
                                begin
                                    phase_next = PH_RX_ACK;
                                    res[n] = make_result(ACT_RX_ACK, '0, '0, OUT_OK, '0);
                                end
                                else
                                begin
                                    phase_next = PH_RX_NACK;
                                    res[n] = make_result(ACT_RX_NACK, '0, '0, OUT_OK, '0);
                                end
                                n = n + 2'd1;
                            end
                        end
                        PH_RX_NACK:
                        begin
                            phase_next = PH_IDLE;
                            if (s != ST_DATA_R_NAK)
                            begin
                                res[n] = make_result(ACT_DONE, '0, '0, OUT_UNEXP, s);
                                n = n + 2'd1;
                            end
                            else
                            begin
                                read_left_next = '0;
                                res[n] = make_result(ACT_READ, '0, data_reg, OUT_OK, '0);
                                n = n + 2'd1;
                                res[n] = make_result(ACT_STOP, '0, '0, OUT_OK, '0);
                                n = n + 2'd1;
                                res[n] = make_result(ACT_DONE, '0, '0, OUT_OK, '0);
                                n = n + 2'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end

        case (n)
            2'd1:    res[0].last = 1'b1;
            2'd2:    res[1].last = 1'b1;
            2'd3:    res[2].last = 1'b1;
            default: ;
        endcase
        n_res = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            phase_reg       <= PH_IDLE;
            addr_left_reg   <= '0;
            write_left_reg  <= '0;
            read_left_reg   <= '0;
            target_reg      <= '0;
            wrote_reg       <= 1'b0;
            stop_pend_reg   <= 1'b0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (item.ready)
            begin
                stage_valid_reg <= item.valid;
            end
            phase_reg      <= phase_next;
            addr_left_reg  <= addr_left_next;
            write_left_reg <= write_left_next;
            read_left_reg  <= read_left_next;
            target_reg     <= target_next;
            wrote_reg      <= wrote_next;
            stop_pend_reg  <= stop_pend_next;
            wr_ptr_reg     <= wr_ptr_reg + PtrWidth'(n_res);
            rd_ptr_reg     <= rd_ptr_reg + PtrWidth'(pop);
            count_reg      <= count_after_pop + CntWidth'(n_res);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg   <= item.kind;
            dev_reg    <= item.device_address;
            acnt_reg   <= item.address_count;
            wcnt_reg   <= item.write_count;
            rcnt_reg   <= item.read_count;
            data_reg   <= item.data_byte;
            status_reg <= item.bus_status;
        end
        for (int i = 0; i < MaxResults; i++)
        begin
            if (2'(i) < n_res)
            begin
                queue_reg[wr_ptr_reg + PtrWidth'(i)] <= res[i];
            end
        end
    end

    assign result.valid      = (count_reg != '0);
    assign result.action     = queue_reg[rd_ptr_reg].action;
    assign result.tx_byte    = queue_reg[rd_ptr_reg].tx_byte;
    assign result.read_byte  = queue_reg[rd_ptr_reg].read_byte;
    assign result.outcome    = queue_reg[rd_ptr_reg].outcome;
    assign result.final_code = queue_reg[rd_ptr_reg].final_code;
    assign result.last       = queue_reg[rd_ptr_reg].last;

endmodule
